@@ hdl/lbp_pkg.sv @@
// lbp_pkg: shared constants and types for the lsb-first bit packer
// no dependencies; used by the channel interfaces and the top level
package lbp_pkg;

    localparam int unsigned WORD_BITS = 32;
    localparam int unsigned LEN_W     = 6;
    localparam int unsigned BLK_W     = 16;
    localparam int unsigned COUNT_W   = 17;

    localparam logic [BLK_W-1:0] BLOCK_WORDS_RESET = 16'd1024;
    localparam logic [LEN_W-1:0] FULL_LEN          = 6'd32;

    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [LEN_W-1:0]     t_len;
    typedef logic [BLK_W-1:0]     t_blk;
    typedef logic [COUNT_W-1:0]   t_count;

endpackage

@@ hdl/lbp_if.sv @@
// lbp_in_if / lbp_out_if: valid-ready channels for codes and packed results
// depends on lbp_pkg
interface lbp_in_if
    import lbp_pkg::*;
();
    logic  valid;
    logic  ready;
    t_word code_value;
    t_len  code_length;

    modport source (output valid, output code_value, output code_length, input ready);
    modport sink   (input valid, input code_value, input code_length, output ready);
endinterface

interface lbp_out_if
    import lbp_pkg::*;
();
    logic  valid;
    logic  ready;
    logic  word_valid;
    t_word packed_word;
    logic  block_overflow;

    modport source (output valid, output word_valid, output packed_word,
                    output block_overflow, input ready);
    modport sink   (input valid, input word_valid, input packed_word,
                    input block_overflow, output ready);
endinterface

@@ hdl/lsb_first_bit_packer.sv @@
// lsb_first_bit_packer: packs 0..32 bit codes lsb first into 32-bit words
// depends on lbp_pkg and the channel interfaces in lbp_if.sv
//
//   port        dir  contents
//   i_code      in   code_value[31:0], code_length[5:0]
//   o_result    out  word_valid, packed_word[31:0], block_overflow
//   i_cfg_wr_*  in   block_words[15:0], write only
//
// one code per cycle unless o_result stalls; each code passes through the
// input register, then the result register; each takes a new transfer when
// the stage after it is free, so a stall on o_result backs up through both
// the barrel shift, or and word count update form the single state loop
// synchronous active-low reset clears state; block_words returns to 1024
module lsb_first_bit_packer
    import lbp_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr_en,
    input  t_blk            i_cfg_wr_data,
    lbp_in_if.sink          i_code,
    lbp_out_if.source       o_result
);

    t_blk   r_block_words;
    logic   r_in_valid;
    t_word  r_in_code;
    t_len   r_in_len;
    t_word  r_acc;
    t_len   r_free_bits;
    t_count r_words_done;
    logic   r_out_valid;
    logic   r_out_word_valid;
    t_word  r_out_packed_word;
    logic   r_out_overflow;

    logic   advance;
    logic   in_ready;
    t_len   len_c;
    t_word  mask;
    t_word  code_m;
    logic [4:0] fill;
    t_word  acc_or;
    logic   complete;
    logic   emit;
    t_len   rest_len;
    t_word  n_acc;
    t_len   n_free_bits;
    t_count n_words_done;
    logic [COUNT_W:0] used;
    logic   n_overflow;

    assign advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign in_ready = !r_in_valid || advance;
    assign i_code.ready = in_ready;

    always_comb begin
        len_c    = (r_in_len > FULL_LEN) ? FULL_LEN : r_in_len;
        mask     = (len_c == FULL_LEN) ? '1 : ~({WORD_BITS{1'b1}} << len_c[4:0]);
        code_m   = r_in_code & mask;
        fill     = 5'(FULL_LEN - r_free_bits);
        acc_or   = r_acc | (code_m << fill);
        complete = (len_c >= r_free_bits);
        emit     = complete && (r_words_done < {1'b0, r_block_words});
        rest_len = len_c - r_free_bits;

        n_acc        = acc_or;
        n_free_bits  = r_free_bits - len_c;
        n_words_done = r_words_done;
        if (complete) begin
            if (r_words_done <= {1'b0, r_block_words}) begin
                n_words_done = r_words_done + t_count'(1);
            end
            if (len_c == r_free_bits) begin
                n_acc       = '0;
                n_free_bits = FULL_LEN;
            end else begin
                n_acc       = code_m >> r_free_bits[4:0];
                n_free_bits = FULL_LEN - rest_len;
            end
        end

        used       = {1'b0, n_words_done} + (COUNT_W+1)'(n_free_bits < FULL_LEN);
        n_overflow = used > (COUNT_W+1)'(r_block_words);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_words <= BLOCK_WORDS_RESET;
            r_in_valid    <= 1'b0;
            r_acc         <= '0;
            r_free_bits   <= FULL_LEN;
            r_words_done  <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_block_words <= i_cfg_wr_data;
            end
            if (in_ready) begin
                r_in_valid <= i_code.valid;
            end
            if (advance) begin
                r_acc        <= n_acc;
                r_free_bits  <= n_free_bits;
                r_words_done <= n_words_done;
                r_out_valid  <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_code.valid) begin
            r_in_code <= i_code.code_value;
            r_in_len  <= i_code.code_length;
        end
        if (advance) begin
            r_out_word_valid  <= emit;
            r_out_packed_word <= emit ? acc_or : '0;
            r_out_overflow    <= n_overflow;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.word_valid     = r_out_word_valid;
    assign o_result.packed_word    = r_out_packed_word;
    assign o_result.block_overflow = r_out_overflow;

`ifndef SYNTHESIS
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free_bits != '0 && r_free_bits <= FULL_LEN)
        else $error("free bit count out of range");

    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |=> r_out_valid)
        else $error("processed code left no result");

    a_dropped_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_word_valid |-> r_out_packed_word == '0)
        else $error("dropped word not zero");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_words_done == $past(r_words_done)
                            || r_words_done == $past(r_words_done) + t_count'(1)))
        else $error("word count moved by more than one");

    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !advance |=> $stable(r_free_bits) && $stable(r_acc))
        else $error("packer state changed without a code");
`endif

endmodule
